// ===== rtl/uart_frame_parser_crc16_unit_assert.svh =====
// Assertion macros for the framed UART parser checker.
// No dependencies; included by the checker file.
`ifndef UART_FRAME_PARSER_CRC16_UNIT_ASSERT_SVH
`define UART_FRAME_PARSER_CRC16_UNIT_ASSERT_SVH

// Clocked assertion, muted while reset is asserted.
`define UFP_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define UFP_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/ufp_pkg.sv =====
// Shared types and constants for the framed UART parser.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package ufp_pkg;

	localparam logic [7:0]  HDR_FIRST  = 8'hAA;
	localparam logic [7:0]  HDR_SECOND = 8'hBB;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd2;

	localparam logic [7:0] RST_CMD_TYPE = 8'd1;
	localparam logic [7:0] RST_ACK_TYPE = 8'd2;
	localparam logic [7:0] RST_MAX_LEN  = 8'd255;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_HDR2 = 3'd1,
		PH_LEN  = 3'd2,
		PH_IDLO = 3'd3,
		PH_IDHI = 3'd4,
		PH_TYPE = 3'd5,
		PH_DATA = 3'd6,
		PH_CRC  = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		EV_PAYLOAD = 3'd0,
		EV_CMD     = 3'd1,
		EV_ACK     = 3'd2,
		EV_CRCERR  = 3'd3,
		EV_LENERR  = 3'd4,
		EV_BADTYPE = 3'd5
	} ev_t;

	typedef struct packed {
		logic [7:0] cmd_type;
		logic [7:0] ack_type;
		logic [7:0] max_len;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [7:0]  payload_byte;
		logic [15:0] message_id;
		logic [7:0]  payload_length;
		logic [15:0] frame_crc;
	} res_t;

endpackage

// ===== rtl/ufp_ifs.sv =====
// Valid/ready channel interfaces: received bytes, parser events, register writes.
// Depends on ufp_pkg for the register index width.
`timescale 1ns / 1ps

interface ufp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufp_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [7:0]  payload_byte;
	logic [15:0] message_id;
	logic [7:0]  payload_length;
	logic [15:0] frame_crc;

	modport source (output valid, output event_kind, output payload_byte,
		output message_id, output payload_length, output frame_crc, input ready);
	modport sink   (input valid, input event_kind, input payload_byte,
		input message_id, input payload_length, input frame_crc, output ready);
endinterface

interface ufp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ufp_pkg::CFG_IDX_W-1:0]  index;
	logic [7:0]                     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ufp_crc_step.sv =====
// One-byte CRC-16/XMODEM update (poly 0x1021, MSB first).
// Depends on ufp_pkg.
`timescale 1ns / 1ps

module ufp_crc_step (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import ufp_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

// ===== rtl/ufp_parser.sv =====
// Frame parser state machine: header hunt, field capture, CRC check, events.
// Depends on ufp_pkg and ufp_crc_step.
`timescale 1ns / 1ps

module ufp_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,      // consume rx_byte this cycle
	input  logic [7:0]      rx_byte,
	input  ufp_pkg::cfg_t   cfg,
	output logic            hit,       // rx_byte yields an event
	output ufp_pkg::res_t   res
);
	import ufp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] id_q, id_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  rem_q, rem_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;

	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic [7:0]  rem_dec;
	logic        type_bad;
	logic [15:0] rx_crc;

	// CRC restarts at the length byte
	assign crc_base = (phase_q == PH_LEN) ? 16'h0000 : crc_q;

	ufp_crc_step u_crc (
		.crc_in  (crc_base),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	assign rem_dec  = rem_q - 8'd1;
	assign type_bad = (rx_byte != cfg.ack_type) && (rx_byte != cfg.cmd_type);
	assign rx_crc   = {rx_byte, crc_lo_q};

	// Next state
	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		id_d     = id_q;
		type_d   = type_q;
		rem_d    = rem_q;
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == HDR_FIRST) phase_d = PH_HDR2;
			end
			PH_HDR2: begin
				phase_d = (rx_byte == HDR_SECOND) ? PH_LEN : PH_HUNT;
			end
			PH_LEN: begin
				if (rx_byte >= cfg.max_len) begin
					phase_d = PH_HUNT;
				end else begin
					len_d   = rx_byte;
					crc_d   = crc_next;
					phase_d = PH_IDLO;
				end
			end
			PH_IDLO: begin
				id_d    = {8'h00, rx_byte};
				crc_d   = crc_next;
				phase_d = PH_IDHI;
			end
			PH_IDHI: begin
				id_d    = {rx_byte, id_q[7:0]};
				crc_d   = crc_next;
				phase_d = PH_TYPE;
			end
			PH_TYPE: begin
				type_d = rx_byte;
				if (type_bad) begin
					phase_d = PH_HUNT;
				end else begin
					crc_d = crc_next;
					if (len_q == 8'd0) begin
						rem_d   = 8'd2;
						phase_d = PH_CRC;
					end else begin
						rem_d   = len_q;
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				crc_d = crc_next;
				if (rem_dec == 8'd0) begin
					rem_d   = 8'd2;
					phase_d = PH_CRC;
				end else begin
					rem_d = rem_dec;
				end
			end
			PH_CRC: begin
				if (rem_q != 8'd1) begin
					crc_lo_d = rx_byte;
					rem_d    = 8'd1;
				end else begin
					rem_d   = 8'd0;
					phase_d = PH_HUNT;
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	// Event outputs
	always_comb begin
		hit = 1'b0;
		res = '0;
		case (phase_q)
			PH_LEN: begin
				if (rx_byte >= cfg.max_len) begin
					hit                = 1'b1;
					res.event_kind     = EV_LENERR;
					res.payload_length = rx_byte;
				end
			end
			PH_TYPE: begin
				if (type_bad) begin
					hit                = 1'b1;
					res.event_kind     = EV_BADTYPE;
					res.message_id     = id_q;
					res.payload_length = len_q;
				end
			end
			PH_DATA: begin
				hit                = 1'b1;
				res.event_kind     = EV_PAYLOAD;
				res.payload_byte   = rx_byte;
				res.message_id     = id_q;
				res.payload_length = len_q;
			end
			PH_CRC: begin
				if (rem_q == 8'd1) begin
					hit                = 1'b1;
					res.message_id     = id_q;
					res.payload_length = len_q;
					res.frame_crc      = rx_crc;
					if (rx_crc != crc_q) begin
						res.event_kind = EV_CRCERR;
					end else if (type_q == cfg.ack_type) begin
						res.event_kind = EV_ACK;
					end else begin
						res.event_kind = EV_CMD;
					end
				end
			end
			default: hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			len_q    <= '0;
			id_q     <= '0;
			type_q   <= '0;
			rem_q    <= '0;
			crc_q    <= '0;
			crc_lo_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			id_q     <= id_d;
			type_q   <= type_d;
			rem_q    <= rem_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

// ===== rtl/uart_frame_parser_crc16_unit.sv =====
// Framed UART receive parser with CRC-16/XMODEM check, top level.
// Each byte is held in the input register, then any event it yields is captured
// in the event register, which drives the event port.
// Throughput: one byte per cycle; the parser FSM and a one-byte CRC step sit
// between the input register and the event register. Only a stalled event stalls input.
// Reset: arst_n async low; parser hunts for header, registers take defaults.
// Depends on ufp_pkg, ufp_ifs, ufp_parser, ufp_crc_step.
`timescale 1ns / 1ps

module uart_frame_parser_crc16_unit (
	input  logic       clk,
	input  logic       arst_n,
	ufp_byte_if.sink   rx,
	ufp_event_if.source evt,
	ufp_cfg_if.sink    cfg
);
	import ufp_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers. Writes are always taken; an index past
	// the register list is dropped.
	// ------------------------------------------------------------------
	cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cmd_type <= RST_CMD_TYPE;
			cfg_q.ack_type <= RST_ACK_TYPE;
			cfg_q.max_len  <= RST_MAX_LEN;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_CMD_TYPE: cfg_q.cmd_type <= cfg.data;
				CFG_ACK_TYPE: cfg_q.ack_type <= cfg.data;
				CFG_MAX_LEN:  cfg_q.max_len  <= cfg.data;
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register. The held byte is consumed (parser state
	// advances) once the event register can take whatever it produces,
	// i.e. the event register is empty or being drained this cycle.
	// Bytes with no event wait on a stalled event too, else move through at full rate.
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic       valid_s2;
	res_t       res_s2;

	assign advance  = valid_s1 && (!valid_s2 || evt.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// ------------------------------------------------------------------
	// Parser: phase, frame fields and running CRC; flags an event for
	// the byte held in stage 1.
	// ------------------------------------------------------------------
	logic hit;
	res_t res_d;

	ufp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.hit     (hit),
		.res     (res_d)
	);

	// ------------------------------------------------------------------
	// Stage 2: event register. Holds one event until its transaction
	// completes; refilled in the same cycle it drains.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= hit;
		end else if (evt.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			res_s2 <= res_d;
		end
	end

	assign evt.valid          = valid_s2;
	assign evt.event_kind     = res_s2.event_kind;
	assign evt.payload_byte   = res_s2.payload_byte;
	assign evt.message_id     = res_s2.message_id;
	assign evt.payload_length = res_s2.payload_length;
	assign evt.frame_crc      = res_s2.frame_crc;

endmodule

// ===== rtl/ufp_checker.sv =====
// Port-level checker for the framed UART parser, bound to the top level.
// Depends on ufp_pkg and uart_frame_parser_crc16_unit_assert.svh.
`timescale 1ns / 1ps
`include "uart_frame_parser_crc16_unit_assert.svh"

module ufp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_ready,
	input logic        evt_valid,
	input logic        evt_ready,
	input logic [2:0]  event_kind,
	input logic [7:0]  payload_byte,
	input logic [15:0] frame_crc
);
	import ufp_pkg::*;

	logic evt_stall;
	logic kind_ok;
	logic crc_free;

	assign evt_stall = evt_valid && !evt_ready;
	assign kind_ok   = (event_kind == EV_PAYLOAD) || (event_kind == EV_CMD) ||
		(event_kind == EV_ACK) || (event_kind == EV_CRCERR) ||
		(event_kind == EV_LENERR) || (event_kind == EV_BADTYPE);
	assign crc_free  = (event_kind == EV_PAYLOAD) || (event_kind == EV_LENERR) ||
		(event_kind == EV_BADTYPE);

	// Stalled event transaction keeps its kind and frame CRC
	`UFP_ASSERT(a_evt_hold, clk, arst_n, evt_stall |=> evt_valid && $stable(event_kind) && $stable(frame_crc), "event changed while stalled")

	// Empty event register never back-pressures the byte side
	`UFP_ASSERT_ALWAYS(a_rx_free, clk, !evt_valid |-> rx_ready, "rx stalled with no pending event")

	`UFP_ASSERT(a_kind_range, clk, arst_n, evt_valid |-> kind_ok, "event kind out of range")

	`UFP_ASSERT(a_pbyte_zero, clk, arst_n, evt_valid && (event_kind != EV_PAYLOAD) |-> payload_byte == 8'h00, "payload byte on final event")

	`UFP_ASSERT(a_crc_zero, clk, arst_n, evt_valid && crc_free |-> frame_crc == 16'h0000, "frame crc on non-final event")

endmodule

bind uart_frame_parser_crc16_unit ufp_checker u_ufp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_ready     (rx.ready),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.event_kind   (evt.event_kind),
	.payload_byte (evt.payload_byte),
	.frame_crc    (evt.frame_crc)
);

// ===== sim/uart_frame_parser_crc16_unit_tb.sv =====
// Self-checking testbench for the framed UART parser with CRC-16/XMODEM check.
// Depends on ufp_pkg, ufp_ifs and the uart_frame_parser_crc16_unit top level.
// Directed frames, register corners and random traffic; events checked in order.
`timescale 1ns / 1ps

module uart_frame_parser_crc16_unit_tb;
	import ufp_pkg::*;

	// Run bounds. The slowest correct run sends about 1100 bytes, some waiting out
	// sender gaps or receiver stalls at 73 percent.
	localparam int CYCLE_LIMIT   = 500000;
	// Idle margin before register writes and at end
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_MAX    = 10;

	// Payload fill modes for the frame builder
	localparam int PAY_RANDOM = 0;
	localparam int PAY_ZERO   = 1;
	localparam int PAY_ONES   = 2;

	// Register index past the end of the list; the block ignores it
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

	logic clk;
	logic arst_n;

	ufp_byte_if  rx_if ();
	ufp_event_if evt_if ();
	ufp_cfg_if   cfg_if ();

	uart_frame_parser_crc16_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.evt    (evt_if),
		.cfg    (cfg_if)
	);

	// Idling knobs, read at falling edges
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;

	int fail_count  = 0;
	int bytes_sent  = 0;
	int cycle_count = 0;

	// Register shadow
	logic [7:0] cfg_cmd_code;
	logic [7:0] cfg_ack_code;
	logic [7:0] cfg_max_len;

	// Parser shadow state
	phase_t      prs_phase;
	logic [7:0]  prs_len;
	logic [15:0] prs_id;
	logic [7:0]  prs_type;
	logic [7:0]  prs_left;
	logic [15:0] prs_crc;
	logic [7:0]  prs_crc_lo;

	// Events the block owes, oldest first
	res_t due_events[$];

	// Byte sequence under construction
	logic [7:0] frame_buf[$];

	//--------------------------------------------------------------------
	// Clock and cycle guard
	//--------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	//--------------------------------------------------------------------
	// Event sink: random backpressure, changed on the falling edge
	//--------------------------------------------------------------------
	initial begin
		evt_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			evt_if.ready = ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	function void log_fault(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%s", msg);
	endfunction

	//--------------------------------------------------------------------
	// Shadow parser
	//--------------------------------------------------------------------
	function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] crc,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	task automatic reset_shadow();
		cfg_cmd_code = RST_CMD_TYPE;
		cfg_ack_code = RST_ACK_TYPE;
		cfg_max_len  = RST_MAX_LEN;
		prs_phase    = PH_HUNT;
		prs_len      = '0;
		prs_id       = '0;
		prs_type     = '0;
		prs_left     = '0;
		prs_crc      = '0;
		prs_crc_lo   = '0;
	endtask

	function automatic res_t make_event(input logic [2:0] kind, input logic [7:0] pbyte,
		input logic [15:0] id, input logic [7:0] len, input logic [15:0] crc);
		res_t ev;
		ev.event_kind     = kind;
		ev.payload_byte   = pbyte;
		ev.message_id     = id;
		ev.payload_length = len;
		ev.frame_crc      = crc;
		return ev;
	endfunction

	// Advance the shadow parser by one accepted byte; queue any event it owes
	task automatic track_frame_byte(input logic [7:0] b);
		logic [15:0] rx_crc;
		case (prs_phase)
			PH_HUNT: begin
				if (b == HDR_FIRST)
					prs_phase = PH_HDR2;
			end
			PH_HDR2: begin
				// a wrong second byte is dropped, not retried as a first byte
				prs_phase = (b == HDR_SECOND) ? PH_LEN : PH_HUNT;
			end
			PH_LEN: begin
				if (b >= cfg_max_len) begin
					prs_phase = PH_HUNT;
					due_events.push_back(make_event(EV_LENERR, 8'h00, 16'h0000, b, 16'h0000));
				end else begin
					prs_len   = b;
					prs_crc   = crc16_xmodem_step(16'h0000, b);
					prs_phase = PH_IDLO;
				end
			end
			PH_IDLO: begin
				prs_id    = {8'h00, b};
				prs_crc   = crc16_xmodem_step(prs_crc, b);
				prs_phase = PH_IDHI;
			end
			PH_IDHI: begin
				prs_id    = {b, prs_id[7:0]};
				prs_crc   = crc16_xmodem_step(prs_crc, b);
				prs_phase = PH_TYPE;
			end
			PH_TYPE: begin
				prs_type = b;
				if (b != cfg_ack_code && b != cfg_cmd_code) begin
					prs_phase = PH_HUNT;
					due_events.push_back(make_event(EV_BADTYPE, 8'h00, prs_id, prs_len,
						16'h0000));
				end else begin
					prs_crc = crc16_xmodem_step(prs_crc, b);
					// zero length skips straight to the CRC bytes
					if (prs_len == 8'h00) begin
						prs_left  = 8'd2;
						prs_phase = PH_CRC;
					end else begin
						prs_left  = prs_len;
						prs_phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				prs_crc  = crc16_xmodem_step(prs_crc, b);
				prs_left = prs_left - 8'd1;
				if (prs_left == 8'h00) begin
					prs_left  = 8'd2;
					prs_phase = PH_CRC;
				end
				due_events.push_back(make_event(EV_PAYLOAD, b, prs_id, prs_len, 16'h0000));
			end
			PH_CRC: begin
				if (prs_left != 8'd1) begin
					prs_crc_lo = b;
					prs_left   = 8'd1;
				end else begin
					rx_crc    = {b, prs_crc_lo};
					prs_left  = 8'h00;
					prs_phase = PH_HUNT;
					// equal type codes resolve to ack
					if (rx_crc != prs_crc)
						due_events.push_back(make_event(EV_CRCERR, 8'h00, prs_id, prs_len,
							rx_crc));
					else if (prs_type == cfg_ack_code)
						due_events.push_back(make_event(EV_ACK, 8'h00, prs_id, prs_len, rx_crc));
					else
						due_events.push_back(make_event(EV_CMD, 8'h00, prs_id, prs_len, rx_crc));
				end
			end
			default: prs_phase = PH_HUNT;
		endcase
	endtask

	//--------------------------------------------------------------------
	// Event checker: one transaction per edge, against the oldest due event
	//--------------------------------------------------------------------
	always @(posedge clk) begin : event_check
		res_t got;
		res_t want;
		if (arst_n && evt_if.valid && evt_if.ready) begin
			got = make_event(evt_if.event_kind, evt_if.payload_byte, evt_if.message_id,
				evt_if.payload_length, evt_if.frame_crc);
			if (due_events.size() == 0) begin
				log_fault($sformatf("unexpected event: kind %0d byte %02h id %04h len %0d crc %04h",
					got.event_kind, got.payload_byte, got.message_id, got.payload_length,
					got.frame_crc));
			end else begin
				want = due_events.pop_front();
				if (got.event_kind !== want.event_kind || got.payload_byte !== want.payload_byte ||
					got.message_id !== want.message_id ||
					got.payload_length !== want.payload_length ||
					got.frame_crc !== want.frame_crc) begin
					log_fault($sformatf({"event mismatch: got kind %0d byte %02h id %04h len %0d",
						" crc %04h, want kind %0d byte %02h id %04h len %0d crc %04h"},
						got.event_kind, got.payload_byte, got.message_id, got.payload_length,
						got.frame_crc, want.event_kind, want.payload_byte, want.message_id,
						want.payload_length, want.frame_crc));
				end
			end
		end
	end

	//--------------------------------------------------------------------
	// Byte source and register port
	//--------------------------------------------------------------------
	// Drive one byte from a falling edge; valid stays up into the next call
	task automatic push_rx_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			rx_if.valid = 1'b0;
			@(negedge clk);
		end
		rx_if.valid   = 1'b1;
		rx_if.rx_byte = b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		track_frame_byte(b);
		bytes_sent++;
	endtask

	// Hold the source off until every due event has come out, then let the pipe empty
	task automatic settle_idle();
		@(negedge clk);
		rx_if.valid = 1'b0;
		while (due_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		settle_idle();
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			CFG_CMD_TYPE: cfg_cmd_code = val;
			CFG_ACK_TYPE: cfg_ack_code = val;
			CFG_MAX_LEN:  cfg_max_len  = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_codes(input logic [7:0] cmd, input logic [7:0] ack,
		input logic [7:0] max_len);
		program_reg(CFG_CMD_TYPE, cmd);
		program_reg(CFG_ACK_TYPE, ack);
		program_reg(CFG_MAX_LEN, max_len);
	endtask

	//--------------------------------------------------------------------
	// Frame building
	//--------------------------------------------------------------------
	task automatic build_frame(input int len, input logic [15:0] id, input logic [7:0] typ,
		input logic [15:0] crc_flip, input int pay_mode);
		logic [15:0] crc;
		logic [7:0]  p;
		frame_buf.delete();
		frame_buf.push_back(HDR_FIRST);
		frame_buf.push_back(HDR_SECOND);
		frame_buf.push_back(8'(len));
		frame_buf.push_back(id[7:0]);
		frame_buf.push_back(id[15:8]);
		frame_buf.push_back(typ);
		crc = crc16_xmodem_step(16'h0000, 8'(len));
		crc = crc16_xmodem_step(crc, id[7:0]);
		crc = crc16_xmodem_step(crc, id[15:8]);
		crc = crc16_xmodem_step(crc, typ);
		for (int i = 0; i < len; i++) begin
			case (pay_mode)
				PAY_ZERO: p = 8'h00;
				PAY_ONES: p = 8'hFF;
				default:  p = 8'($urandom_range(0, 255));
			endcase
			frame_buf.push_back(p);
			crc = crc16_xmodem_step(crc, p);
		end
		crc = crc ^ crc_flip;
		frame_buf.push_back(crc[7:0]);
		frame_buf.push_back(crc[15:8]);
	endtask

	task automatic send_buf(input int count);
		for (int i = 0; i < count; i++)
			push_rx_byte(frame_buf[i]);
	endtask

	// Mostly short payloads, now and then anything the length limit allows
	function automatic int pick_len();
		int hi;
		hi = int'(cfg_max_len) - 1;
		if (hi < 0)
			hi = 0;
		if ($urandom_range(0, 39) == 0)
			return $urandom_range(0, hi);
		return $urandom_range(0, (hi < 10) ? hi : 10);
	endfunction

	function automatic logic [7:0] pick_bad_type();
		logic [7:0] t;
		t = 8'($urandom_range(0, 255));
		while (t == cfg_cmd_code || t == cfg_ack_code)
			t = 8'($urandom_range(0, 255));
		return t;
	endfunction

	function automatic logic [7:0] pick_good_type();
		return $urandom_range(0, 1) ? cfg_cmd_code : cfg_ack_code;
	endfunction

	//--------------------------------------------------------------------
	// Tests
	//--------------------------------------------------------------------
	task automatic test_directed_frames();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		// wrong second header byte; the trailing BB must not start anything
		push_rx_byte(HDR_FIRST);
		push_rx_byte(HDR_FIRST);
		push_rx_byte(HDR_SECOND);
		// largest length against the reset limit is rejected
		push_rx_byte(HDR_FIRST);
		push_rx_byte(HDR_SECOND);
		push_rx_byte(8'hFF);
		// unknown type, zero id and length
		build_frame(0, 16'h0000, 8'h07, 16'h0000, PAY_ZERO);
		send_buf(6);
		// zero length command, all-ones id
		build_frame(0, 16'hFFFF, cfg_cmd_code, 16'h0000, PAY_ZERO);
		send_buf(frame_buf.size());
		// ack with a zero payload byte
		build_frame(1, 16'h1234, cfg_ack_code, 16'h0000, PAY_ZERO);
		send_buf(frame_buf.size());
		// CRC error on an all-ones payload
		build_frame(1, 16'h8001, cfg_cmd_code, 16'h0001, PAY_ONES);
		send_buf(frame_buf.size());
	endtask

	task automatic test_config_corners();
		src_idle_pct   = 20;
		sink_stall_pct = 20;
		// only zero length fits under a limit of one
		set_codes(8'h00, 8'hFF, 8'd1);
		build_frame(0, 16'hA5A5, 8'h00, 16'h0000, PAY_RANDOM);
		send_buf(frame_buf.size());
		build_frame(0, 16'h5A5A, 8'hFF, 16'h0000, PAY_RANDOM);
		send_buf(frame_buf.size());
		build_frame(1, 16'h0101, 8'h00, 16'h0000, PAY_RANDOM);
		send_buf(frame_buf.size());
		// both codes equal: a matching frame reads as ack
		set_codes(8'h55, 8'h55, 8'd16);
		build_frame(2, 16'h7E7E, 8'h55, 16'h0000, PAY_RANDOM);
		send_buf(frame_buf.size());
		// limit zero rejects every length
		program_reg(CFG_MAX_LEN, 8'd0);
		build_frame(0, 16'h0F0F, 8'h55, 16'h0000, PAY_RANDOM);
		send_buf(frame_buf.size());
		// index past the list must change nothing
		program_reg(CFG_IDX_SPARE, 8'($urandom_range(0, 255)));
		set_codes(RST_CMD_TYPE, RST_ACK_TYPE, RST_MAX_LEN);
		// longest payload the limit admits
		build_frame(254, 16'($urandom_range(0, 65535)), cfg_cmd_code, 16'h0000, PAY_RANDOM);
		send_buf(frame_buf.size());
	endtask

	// Source stops mid-frame until the block has delivered everything owed
	task automatic test_drain_pause();
		src_idle_pct   = 0;
		sink_stall_pct = 50;
		build_frame(3, 16'($urandom_range(0, 65535)), cfg_cmd_code, 16'h0000, PAY_RANDOM);
		for (int i = 0; i < frame_buf.size(); i++) begin
			push_rx_byte(frame_buf[i]);
			if ($urandom_range(0, 1))
				settle_idle();
		end
		settle_idle();
		build_frame(2, 16'($urandom_range(0, 65535)), cfg_ack_code, 16'h0000, PAY_RANDOM);
		send_buf(frame_buf.size());
	endtask

	// Mostly well-formed frames with random content, rest broken or noise
	task automatic test_random_traffic(input int n_bytes, input int src_pct, input int sink_pct);
		int target;
		int r;
		int n;
		logic [7:0] b;
		set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(1, 255)));
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 62) begin
				build_frame(pick_len(), 16'($urandom_range(0, 65535)), pick_good_type(),
					16'h0000, PAY_RANDOM);
				send_buf(frame_buf.size());
			end else if (r < 72) begin
				build_frame(pick_len(), 16'($urandom_range(0, 65535)), pick_good_type(),
					16'($urandom_range(1, 65535)), PAY_RANDOM);
				send_buf(frame_buf.size());
			end else if (r < 80) begin
				build_frame(pick_len(), 16'($urandom_range(0, 65535)), pick_bad_type(),
					16'h0000, PAY_RANDOM);
				send_buf(6);
			end else if (r < 86) begin
				push_rx_byte(HDR_FIRST);
				push_rx_byte(HDR_SECOND);
				push_rx_byte(8'($urandom_range(cfg_max_len, 255)));
			end else if (r < 91) begin
				b = 8'($urandom_range(0, 255));
				while (b == HDR_SECOND)
					b = 8'($urandom_range(0, 255));
				push_rx_byte(HDR_FIRST);
				push_rx_byte(b);
			end else if (r < 95) begin
				// cut short; the next frame's bytes land inside this one
				build_frame(pick_len(), 16'($urandom_range(0, 65535)), pick_good_type(),
					16'h0000, PAY_RANDOM);
				send_buf($urandom_range(3, frame_buf.size() - 1));
			end else begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					push_rx_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	//--------------------------------------------------------------------
	// Sequence
	//--------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = 8'h00;
		cfg_if.valid  = 1'b0;
		cfg_if.index  = CFG_CMD_TYPE;
		cfg_if.data   = 8'h00;
		reset_shadow();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_frames();
		test_config_corners();
		test_drain_pause();
		// idling phases: none, sender gaps, receiver stalls, both
		test_random_traffic(190, 0, 0);
		test_random_traffic(190, 73, 0);
		test_random_traffic(190, 0, 73);
		test_random_traffic(190, 15, 15);

		settle_idle();
		if (fail_count == 0 && due_events.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ufp_pkg.sv
rtl/ufp_ifs.sv
rtl/ufp_crc_step.sv
rtl/ufp_parser.sv
rtl/uart_frame_parser_crc16_unit.sv
rtl/ufp_checker.sv
sim/uart_frame_parser_crc16_unit_tb.sv
